/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication under a synchronous active-high reset.
`define ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication under a synchronous active-high reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hdl/mrtc_pkg.sv */
// Types, codes and constants of the multi-rate tick countdown unit.
// Used by the RTL files of the block but mrtc_cell; depends on nothing.
package mrtc_pkg;

   localparam int BANK_SIZE_DEF = 30;
   localparam int BANK_MAX      = 32;
   localparam int NAMED_COUNT   = 7;
   localparam int CLIP_INDEX    = 4;

   localparam logic [7:0] SUBTICK_RESET = 8'd25;
   localparam logic [7:0] CHAIN_RESET   = 8'd11;
   localparam logic [7:0] SPK_SET       = 8'h03;
   localparam logic [7:0] SPK_CLEAR     = 8'hfc;

   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   localparam logic [5:0] TGT_TICK  = 6'd7;
   localparam logic [5:0] TGT_IDLE  = 6'd8;
   localparam logic [5:0] TGT_MASK  = 6'd9;
   localparam logic [5:0] TGT_SPK   = 6'd10;

   localparam logic [1:0] CSR_HOOK     = 2'd0;
   localparam logic [1:0] CSR_SUBTICK  = 2'd1;
   localparam logic [1:0] CSR_CHAIN    = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [5:0]  target;
      logic [15:0] write_value;
      logic        game_paused;
      logic        hold_bank;
      logic [7:0]  speaker_port_in;
   } req_type;

   typedef struct packed {
      logic        chain_previous;
      logic        end_of_interrupt;
      logic        speaker_write;
      logic [7:0]  speaker_value;
      logic        periodic_ready;
      logic [15:0] read_value;
   } rsp_type;

   // Command for one sweep of the bank ring.
   typedef struct packed {
      logic        dec;
      logic        wr;
      logic        rd;
      logic [4:0]  slot;
      logic [15:0] value;
   } bank_op_type;

   typedef struct packed {
      logic        done;
      logic [15:0] rd_data;
   } bank_stat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_OUT
   } state_type;

endpackage

/* hdl/multi_rate_tick_countdown_unit.sv */
// Top level of the multi-rate tick countdown unit: scalar counters,
// dividers, sequencer and result register. Depends on mrtc_pkg, mrtc_bank.
//
// Each word on req (tick, counter write or counter read) yields exactly one
// word on rsp. The scalar counters and dividers are updated in the cycle the
// word is accepted; the bank timers then rotate once through the cell ring,
// one timer per cycle past the head, and the result register is loaded once
// the rotation is done and rsp is free. The next word is accepted while a
// finished result still waits on rsp. Reload values on the csr port take
// effect at the next divider reload; the hook bit takes effect with the
// next tick word.
module multi_rate_tick_countdown_unit #(
   parameter int BANK_SIZE = mrtc_pkg::BANK_SIZE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mrtc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mrtc_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata
);

   mrtc_pkg::state_type state_ff, state_in;

   logic        hook_ff, hook_in;
   logic [7:0]  sub_reload_ff, sub_reload_in;
   logic [7:0]  chain_reload_ff, chain_reload_in;

   logic [15:0] tick_ff, tick_in;
   logic [7:0]  sub_left_ff, sub_left_in;
   logic [7:0]  chain_left_ff, chain_left_in;
   logic [15:0] nc_ff [mrtc_pkg::NAMED_COUNT];
   logic [15:0] nc_in [mrtc_pkg::NAMED_COUNT];
   logic [15:0] idle_ff, idle_in;
   logic [15:0] mask_ff, mask_in;
   logic [1:0]  spk_req_ff, spk_req_in;
   logic        ready_ff, ready_in;

   mrtc_pkg::rsp_type pend_ff, pend_in;
   logic              bank_rd_ff, bank_rd_in;
   mrtc_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   mrtc_pkg::bank_op_type   bank_op;
   mrtc_pkg::bank_stat_type bank_stat;

   logic accept;
   logic load_rsp;
   logic is_bank;
   logic [4:0] slot;

   assign accept = req_valid && req_ready;
   assign slot   = req_data.target[4:0];
   assign is_bank = req_data.target[5] && (6'(slot) < 6'(BANK_SIZE));

   // Configuration registers.
   always_comb begin
      hook_in         = hook_ff;
      sub_reload_in   = sub_reload_ff;
      chain_reload_in = chain_reload_ff;
      if (csr_we) begin
         unique case (csr_index)
            mrtc_pkg::CSR_HOOK:    hook_in         = csr_wdata[0];
            mrtc_pkg::CSR_SUBTICK: sub_reload_in   = csr_wdata;
            mrtc_pkg::CSR_CHAIN:   chain_reload_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Scalar update of one accepted word.
   always_comb begin
      logic [15:0] tc;
      logic        b1, b2, b3, b4, b5, fire;
      tc   = tick_ff + 16'd1;
      b1   = (tc[0] == 1'b0);
      b2   = (tc[1:0] == 2'd0);
      b3   = (tc[2:0] == 3'd0);
      b4   = (tc[3:0] == 4'd0);
      b5   = (tc[4:0] == 5'd0);
      fire = b3 && (sub_left_ff == 8'd1);

      tick_in       = tick_ff;
      sub_left_in   = sub_left_ff;
      chain_left_in = chain_left_ff;
      nc_in         = nc_ff;
      idle_in       = idle_ff;
      mask_in       = mask_ff;
      spk_req_in    = spk_req_ff;
      ready_in      = ready_ff;
      pend_in       = pend_ff;
      bank_rd_in    = bank_rd_ff;
      bank_op       = '{dec: 1'b0, wr: 1'b0, rd: 1'b0, slot: slot,
                        value: req_data.write_value};

      if (accept) begin
         pend_in    = '0;
         bank_rd_in = 1'b0;
         unique case (req_data.mode)
            mrtc_pkg::MODE_TICK: begin
               if (!hook_ff) begin
                  pend_in.chain_previous = 1'b1;
               end else begin
                  if (chain_left_ff == 8'd1) begin
                     chain_left_in          = chain_reload_ff;
                     pend_in.chain_previous = 1'b1;
                  end else begin
                     chain_left_in            = chain_left_ff - 8'd1;
                     pend_in.end_of_interrupt = 1'b1;
                  end
                  if (!req_data.game_paused) begin
                     tick_in  = tc;
                     ready_in = b5;
                     if (nc_ff[0] != 16'd0) nc_in[0] = nc_ff[0] - 16'd1;
                     if (b1 && nc_ff[1] != 16'd0) nc_in[1] = nc_ff[1] - 16'd1;
                     if (b2 && nc_ff[2] != 16'd0) nc_in[2] = nc_ff[2] - 16'd1;
                     if (b3 && nc_ff[3] != 16'd0) nc_in[3] = nc_ff[3] - 16'd1;
                     if (b3) begin
                        sub_left_in = fire ? sub_reload_ff : sub_left_ff - 8'd1;
                     end
                     if (fire) begin
                        idle_in     = idle_ff + 16'd1;
                        bank_op.dec = !req_data.hold_bank;
                        if (nc_ff[mrtc_pkg::CLIP_INDEX] != 16'd0) begin
                           nc_in[mrtc_pkg::CLIP_INDEX] =
                              nc_ff[mrtc_pkg::CLIP_INDEX] - 16'd1;
                        end
                     end
                     if (b4) begin
                        mask_in = mask_ff + 16'd1;
                        if (nc_ff[5] != 16'd0) nc_in[5] = nc_ff[5] - 16'd1;
                     end
                     if (b5) begin
                        if (nc_ff[6] != 16'd0) nc_in[6] = nc_ff[6] - 16'd1;
                        // Toggle the speaker gate on request.
                        if (spk_req_ff[0]) begin
                           pend_in.speaker_write = 1'b1;
                           if (!spk_req_ff[1]) begin
                              pend_in.speaker_value = req_data.speaker_port_in
                                                      | mrtc_pkg::SPK_SET;
                              spk_req_in = 2'd3;
                           end else begin
                              pend_in.speaker_value = req_data.speaker_port_in
                                                      & mrtc_pkg::SPK_CLEAR;
                              spk_req_in = 2'd0;
                           end
                        end
                     end
                  end
               end
            end
            mrtc_pkg::MODE_WRITE: begin
               if (is_bank) begin
                  bank_op.wr = 1'b1;
               end else if (req_data.target < 6'(mrtc_pkg::NAMED_COUNT)) begin
                  nc_in[req_data.target[2:0]] = req_data.write_value;
               end else if (req_data.target == mrtc_pkg::TGT_TICK) begin
                  tick_in = req_data.write_value;
               end else if (req_data.target == mrtc_pkg::TGT_IDLE) begin
                  idle_in = req_data.write_value;
               end else if (req_data.target == mrtc_pkg::TGT_MASK) begin
                  mask_in = req_data.write_value;
               end else if (req_data.target == mrtc_pkg::TGT_SPK) begin
                  spk_req_in = req_data.write_value[1:0];
               end
            end
            mrtc_pkg::MODE_READ: begin
               if (is_bank) begin
                  bank_op.rd = 1'b1;
                  bank_rd_in = 1'b1;
               end else if (req_data.target < 6'(mrtc_pkg::NAMED_COUNT)) begin
                  pend_in.read_value = nc_ff[req_data.target[2:0]];
               end else if (req_data.target == mrtc_pkg::TGT_TICK) begin
                  pend_in.read_value = tick_ff;
               end else if (req_data.target == mrtc_pkg::TGT_IDLE) begin
                  pend_in.read_value = idle_ff;
               end else if (req_data.target == mrtc_pkg::TGT_MASK) begin
                  pend_in.read_value = mask_ff;
               end else if (req_data.target == mrtc_pkg::TGT_SPK) begin
                  pend_in.read_value = {14'd0, spk_req_ff};
               end
            end
            default: ;
         endcase
         pend_in.periodic_ready = ready_in;
      end
   end

   mrtc_bank #(
      .BANK_SIZE (BANK_SIZE)
   ) u_bank (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .op    (bank_op),
      .stat  (bank_stat)
   );

   // Sequencer: next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mrtc_pkg::ST_IDLE:  if (accept) state_in = mrtc_pkg::ST_SWEEP;
         mrtc_pkg::ST_SWEEP: if (bank_stat.done) state_in = mrtc_pkg::ST_OUT;
         mrtc_pkg::ST_OUT:   if (!rsp_valid_ff || rsp_ready) state_in = mrtc_pkg::ST_IDLE;
         default:            state_in = mrtc_pkg::ST_IDLE;
      endcase
   end

   // Sequencer: outputs.
   always_comb begin
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         mrtc_pkg::ST_IDLE:  req_ready = 1'b1;
         mrtc_pkg::ST_SWEEP: ;
         mrtc_pkg::ST_OUT:   load_rsp = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (load_rsp) begin
         rsp_in = pend_ff;
         if (bank_rd_ff) rsp_in.read_value = bank_stat.rd_data;
      end
   end

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= mrtc_pkg::ST_IDLE;
         hook_ff         <= 1'b0;
         sub_reload_ff   <= mrtc_pkg::SUBTICK_RESET;
         chain_reload_ff <= mrtc_pkg::CHAIN_RESET;
         tick_ff         <= '0;
         sub_left_ff     <= mrtc_pkg::SUBTICK_RESET;
         chain_left_ff   <= mrtc_pkg::CHAIN_RESET;
         nc_ff           <= '{default: '0};
         idle_ff         <= '0;
         mask_ff         <= '0;
         spk_req_ff      <= '0;
         ready_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         hook_ff         <= hook_in;
         sub_reload_ff   <= sub_reload_in;
         chain_reload_ff <= chain_reload_in;
         tick_ff         <= tick_in;
         sub_left_ff     <= sub_left_in;
         chain_left_ff   <= chain_left_in;
         nc_ff           <= nc_in;
         idle_ff         <= idle_in;
         mask_ff         <= mask_in;
         spk_req_ff      <= spk_req_in;
         ready_ff        <= ready_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      pend_ff    <= pend_in;
      bank_rd_ff <= bank_rd_in;
      rsp_ff     <= rsp_in;
   end

endmodule

/* hdl/mrtc_cell.sv */
// One cell of the bank timer ring: a 16-bit timer that takes its
// neighbor's word on each shift. Depends on nothing.
module mrtc_cell (
   input  logic        clock,
   input  logic        reset,
   input  logic        shift,
   input  logic [15:0] d,
   output logic [15:0] q
);

   logic [15:0] value_ff;
   logic [15:0] value_in;

   assign value_in = shift ? d : value_ff;
   assign q        = value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

endmodule

/* hdl/mrtc_bank.sv */
// Bank timer ring: a chain of mrtc_cell rotated once per item, with the
// decrement, load and capture done at the head. Depends on mrtc_pkg, mrtc_cell.
module mrtc_bank #(
   parameter int BANK_SIZE = mrtc_pkg::BANK_SIZE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  mrtc_pkg::bank_op_type op,
   output mrtc_pkg::bank_stat_type stat
);

   localparam logic [4:0] LAST_POS = 5'(BANK_SIZE - 1);

   logic                  busy_ff, busy_in;
   logic [4:0]            pos_ff, pos_in;
   mrtc_pkg::bank_op_type op_ff, op_in;
   logic [15:0]           rd_ff, rd_in;
   logic [15:0]           cell_q [BANK_SIZE];
   logic [15:0]           head_new;
   logic                  hit;
   logic                  last;

   assign hit  = (pos_ff == op_ff.slot);
   assign last = busy_ff && (pos_ff == LAST_POS);

   // Head cell: load on a write hit, else on a decrement drop positive timers by one.
   always_comb begin
      head_new = cell_q[0];
      if (op_ff.wr && hit) begin
         head_new = op_ff.value;
      end else if (op_ff.dec && (cell_q[0] != 16'd0) && !cell_q[0][15]) begin
         head_new = cell_q[0] - 16'd1;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      op_in   = op_ff;
      rd_in   = rd_ff;
      if (start) begin
         busy_in = 1'b1;
         pos_in  = '0;
         op_in   = op;
         rd_in   = '0;
      end else if (busy_ff) begin
         if (op_ff.rd && hit) begin
            rd_in = cell_q[0];
         end
         pos_in = pos_ff + 5'd1;
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
      op_ff <= op_in;
      rd_ff <= rd_in;
   end

   genvar k;
   generate
      for (k = 0; k < BANK_SIZE; k++) begin : g_cell
         logic [15:0] d;
         if (k == BANK_SIZE - 1) begin : g_tail
            assign d = head_new;
         end else begin : g_mid
            assign d = cell_q[k + 1];
         end
         mrtc_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (busy_ff),
            .d     (d),
            .q     (cell_q[k])
         );
      end
   endgenerate

   assign stat.done    = last;
   assign stat.rd_data = rd_ff;

endmodule

/* hdl/mrtc_checker.sv */
// Port-level checks of the multi-rate tick countdown unit and their bind.
// Depends on mrtc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mrtc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input mrtc_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mrtc_pkg::rsp_type rsp_data
);

   logic req_fire;
   logic chain_shown;
   logic spk_idle;
   assign req_fire = req_valid && req_ready && (req_data.mode == mrtc_pkg::MODE_TICK);
   assign chain_shown = rsp_valid && rsp_data.chain_previous;
   assign spk_idle    = rsp_valid && !rsp_data.speaker_write;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_NOW(a_chain_xor_eoi, clock, reset, chain_shown, !rsp_data.end_of_interrupt)
   `ASSERT_NOW(a_spk_quiet, clock, reset, spk_idle, rsp_data.speaker_value == 8'd0)
   `ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_NEXT(a_tick_no_read, clock, reset, req_fire, !req_ready)

endmodule

bind multi_rate_tick_countdown_unit mrtc_checker u_mrtc_checker (.*);
